// ===== sv/bsf_pkg.sv =====
// shared types, constants and weight table for the binomial smoothing filter
`default_nettype none
package bsf_pkg;

  localparam int MAX_TAPS     = 7;
  localparam int SAMPLE_WIDTH = 32;
  localparam int LEN_W        = 3;
  localparam int WEIGHT_W     = 6;
  localparam int PROD_W       = SAMPLE_WIDTH + WEIGHT_W + 1;
  localparam int SUM_W        = SAMPLE_WIDTH + MAX_TAPS + 1;
  localparam int NPAIR        = (MAX_TAPS + 1) / 2;
  localparam int NCHAN        = 2;
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TAPS);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef prod_t prod_vec_t [MAX_TAPS];

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] time_value;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] smoothed_time;
    logic signed [SAMPLE_WIDTH-1:0] smoothed_sample;
  } out_t;

  // row r of pascal's triangle, zero past its end
  localparam logic [WEIGHT_W-1:0] PASCAL [MAX_TAPS][MAX_TAPS] = '{
    '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0, 6'd0},
    '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1, 6'd0},
    '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6, 6'd1}
  };

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = v;
    if (n < MIN_LEN) n = MIN_LEN;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bsf_lane.sv =====
// one channel: tap line of the last samples and the weighted products of all taps
`default_nettype none
module bsf_lane (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire logic                     en,
  input  wire bsf_pkg::sample_t         din,
  input  wire logic [bsf_pkg::LEN_W-1:0] len,
  output bsf_pkg::prod_vec_t            prod
);

  bsf_pkg::sample_t  taps [bsf_pkg::MAX_TAPS];
  bsf_pkg::sample_t  line [bsf_pkg::MAX_TAPS];
  bsf_pkg::prod_vec_t prod_next;
  logic [bsf_pkg::LEN_W-1:0] row;

  // newest sample sits in tap 0; the row is symmetric so tap order does not matter
  always_comb begin
    row = len - bsf_pkg::LEN_W'(1);
    line[0] = din;
    for (int i = 1; i < bsf_pkg::MAX_TAPS; i++) begin
      line[i] = taps[i-1];
    end
    for (int i = 0; i < bsf_pkg::MAX_TAPS; i++) begin
      prod_next[i] = bsf_pkg::PROD_W'(line[i]) *
                     bsf_pkg::prod_t'({1'b0, bsf_pkg::PASCAL[row][i]});
    end
  end

  // taps past the window carry zero weight but must still hold known values
  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= '{default: '0};
    end else if (load) begin
      taps <= line;
    end
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bsf_merge.sv =====
// adder tree over the lane products, then the floor shift by n-1
`default_nettype none
module bsf_merge (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [bsf_pkg::LEN_W-1:0] len,
  input  wire bsf_pkg::prod_vec_t        time_prod,
  input  wire bsf_pkg::prod_vec_t        sample_prod,
  output bsf_pkg::out_t                  result
);

  bsf_pkg::sum_t pair   [bsf_pkg::NCHAN][bsf_pkg::NPAIR];
  bsf_pkg::sum_t pair_next [bsf_pkg::NCHAN][bsf_pkg::NPAIR];
  bsf_pkg::sum_t padded [bsf_pkg::NCHAN][2*bsf_pkg::NPAIR];
  bsf_pkg::sum_t total  [bsf_pkg::NCHAN];
  bsf_pkg::sum_t scaled [bsf_pkg::NCHAN];
  bsf_pkg::out_t result_next;
  logic [bsf_pkg::LEN_W-1:0] shift;

  always_comb begin
    for (int i = 0; i < 2*bsf_pkg::NPAIR; i++) begin
      padded[0][i] = '0;
      padded[1][i] = '0;
    end
    for (int i = 0; i < bsf_pkg::MAX_TAPS; i++) begin
      padded[0][i] = bsf_pkg::SUM_W'(time_prod[i]);
      padded[1][i] = bsf_pkg::SUM_W'(sample_prod[i]);
    end
    for (int c = 0; c < bsf_pkg::NCHAN; c++) begin
      for (int p = 0; p < bsf_pkg::NPAIR; p++) begin
        pair_next[c][p] = padded[c][2*p] + padded[c][2*p+1];
      end
    end
  end

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    shift = len - bsf_pkg::LEN_W'(1);
    for (int c = 0; c < bsf_pkg::NCHAN; c++) begin
      total[c] = '0;
      for (int p = 0; p < bsf_pkg::NPAIR; p++) begin
        total[c] = total[c] + pair[c][p];
      end
      scaled[c] = total[c] >>> shift;
    end
    result_next.smoothed_time   = scaled[0][bsf_pkg::SAMPLE_WIDTH-1:0];
    result_next.smoothed_sample = scaled[1][bsf_pkg::SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair   <= pair_next;
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/binomial_smoothing_filter.sv =====
// top level of the two-channel binomial smoothing filter
`default_nettype none
// Takes one time/sample beat per clock while in_stall is low and, once the window
// holds N beats (N = window_length, 2..7, values below 2 read as 2), gives one beat
// per input: each channel's binomially weighted sum of the last N values, shifted
// right by N-1 toward minus infinity. The first N-1 beats after reset or after any
// write of window_length give no output. The pipeline registers, in order, the
// weighted products in each channel lane, the pair sums, then the final sum and
// shift. The pipeline holds as a whole while out_stall holds a waiting result. The
// configuration port is always ready; write it only while no beats are in flight.
module binomial_smoothing_filter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire bsf_pkg::in_t              in_data,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      bsf_pkg::out_t             out_data,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [bsf_pkg::LEN_W-1:0] cfg_data
);

  logic                      en;
  logic                      load;
  logic                      emit;
  logic [bsf_pkg::LEN_W-1:0] window_length;
  logic [bsf_pkg::LEN_W-1:0] fill_count;
  logic                      window_full;
  logic                      v1;
  logic                      v2;
  bsf_pkg::prod_vec_t        time_prod;
  bsf_pkg::prod_vec_t        sample_prod;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign load      = in_valid && en;
  assign cfg_ready = 1'b1;
  assign window_full = (fill_count == window_length);
  assign emit = load && (window_full || (fill_count + bsf_pkg::LEN_W'(1) == window_length));

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= bsf_pkg::MIN_LEN;
      fill_count    <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_length <= bsf_pkg::clamp_len(cfg_data);
        fill_count    <= '0;
      end else if (load && !window_full) begin
        fill_count <= fill_count + bsf_pkg::LEN_W'(1);
      end
      if (en) begin
        v1        <= emit;
        v2        <= v1;
        out_valid <= v2;
      end
    end
  end

  bsf_lane u_time_lane (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .en   (en),
    .din  (in_data.time_value),
    .len  (window_length),
    .prod (time_prod)
  );

  bsf_lane u_sample_lane (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .en   (en),
    .din  (in_data.sample_value),
    .len  (window_length),
    .prod (sample_prod)
  );

  bsf_merge u_merge (
    .clk         (clk),
    .en          (en),
    .len         (window_length),
    .time_prod   (time_prod),
    .sample_prod (sample_prod),
    .result      (out_data)
  );

endmodule
`default_nettype wire
